// ----- src/jtd_pkg.sv -----
// Shared types, codes and constants for the JTAG debug transport block.
package jtd_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned ADDR_OUT_W  = 8;
  localparam int unsigned HINT_W      = 3;
  localparam int unsigned S_TDATA_W   = 40;
  localparam int unsigned M_TDATA_W   = 48;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned IR_CODE_W   = 8;

  // Defaults for the top-level parameters
  localparam int unsigned ADDRESS_BITS_DEF = 7;
  localparam int unsigned IR_BITS_DEF      = 5;

  // Item modes (tuser)
  localparam logic [MODE_W-1:0] MODE_PIN   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESET = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_IDCODE    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_HINT = 1'd1;

  // Configuration reset values
  localparam logic [DATA_W-1:0] IDCODE_RESET    = 32'hdeadbeef;
  localparam logic [HINT_W-1:0] IDLE_HINT_RESET = 3'd4;

  // Instruction codes
  localparam logic [IR_CODE_W-1:0] IR_IDCODE = 8'h01;
  localparam logic [IR_CODE_W-1:0] IR_DTMCS  = 8'h10;
  localparam logic [IR_CODE_W-1:0] IR_DMI    = 8'h11;
  localparam logic [IR_CODE_W-1:0] IR_BYPASS = 8'h1f;

  // DMI op field and DTMCS version
  localparam logic [1:0] DMI_OP_READ   = 2'd1;
  localparam logic [1:0] DMI_OP_WRITE  = 2'd2;
  localparam logic [3:0] DTMCS_VERSION = 4'd1;
  localparam int unsigned DMI_OP_W     = 2;

  typedef enum logic [3:0] {
    TAP_TLR     = 4'd0,
    TAP_IDLE    = 4'd1,
    TAP_SEL_DR  = 4'd2,
    TAP_CAP_DR  = 4'd3,
    TAP_SH_DR   = 4'd4,
    TAP_EX1_DR  = 4'd5,
    TAP_PAU_DR  = 4'd6,
    TAP_EX2_DR  = 4'd7,
    TAP_UPD_DR  = 4'd8,
    TAP_SEL_IR  = 4'd9,
    TAP_CAP_IR  = 4'd10,
    TAP_SH_IR   = 4'd11,
    TAP_EX1_IR  = 4'd12,
    TAP_PAU_IR  = 4'd13,
    TAP_EX2_IR  = 4'd14,
    TAP_UPD_IR  = 4'd15
  } tap_state_t;

  // Decodes of the current and the following TAP state
  typedef struct packed {
    logic at_sh_dr;
    logic at_sh_ir;
    logic to_tlr;
    logic to_cap_dr;
    logic to_sh_dr;
    logic to_sh_ir;
    logic to_upd_dr;
  } tap_ctrl_t;

  // Debug module access request
  typedef struct packed {
    logic                  valid;
    logic                  is_write;
    logic [ADDR_OUT_W-1:0] address;
    logic [DATA_W-1:0]     write_data;
  } dm_req_t;

endpackage

// ----- src/jtd_tap.sv -----
// TAP controller: 16-state graph advanced on each rising test clock.
module jtd_tap (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic               tms,
  output jtd_pkg::tap_ctrl_t ctrl
);

  jtd_pkg::tap_state_t state;
  jtd_pkg::tap_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jtd_pkg::TAP_TLR;
    end else if (step) begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      jtd_pkg::TAP_TLR:    state_next = tms ? jtd_pkg::TAP_TLR    : jtd_pkg::TAP_IDLE;
      jtd_pkg::TAP_IDLE:   state_next = tms ? jtd_pkg::TAP_SEL_DR : jtd_pkg::TAP_IDLE;
      jtd_pkg::TAP_SEL_DR: state_next = tms ? jtd_pkg::TAP_SEL_IR : jtd_pkg::TAP_CAP_DR;
      jtd_pkg::TAP_CAP_DR: state_next = tms ? jtd_pkg::TAP_EX1_DR : jtd_pkg::TAP_SH_DR;
      jtd_pkg::TAP_SH_DR:  state_next = tms ? jtd_pkg::TAP_EX1_DR : jtd_pkg::TAP_SH_DR;
      jtd_pkg::TAP_EX1_DR: state_next = tms ? jtd_pkg::TAP_UPD_DR : jtd_pkg::TAP_PAU_DR;
      jtd_pkg::TAP_PAU_DR: state_next = tms ? jtd_pkg::TAP_EX2_DR : jtd_pkg::TAP_PAU_DR;
      jtd_pkg::TAP_EX2_DR: state_next = tms ? jtd_pkg::TAP_UPD_DR : jtd_pkg::TAP_SH_DR;
      jtd_pkg::TAP_UPD_DR: state_next = tms ? jtd_pkg::TAP_SEL_DR : jtd_pkg::TAP_IDLE;
      jtd_pkg::TAP_SEL_IR: state_next = tms ? jtd_pkg::TAP_TLR    : jtd_pkg::TAP_CAP_IR;
      jtd_pkg::TAP_CAP_IR: state_next = tms ? jtd_pkg::TAP_EX1_IR : jtd_pkg::TAP_SH_IR;
      jtd_pkg::TAP_SH_IR:  state_next = tms ? jtd_pkg::TAP_EX1_IR : jtd_pkg::TAP_SH_IR;
      jtd_pkg::TAP_EX1_IR: state_next = tms ? jtd_pkg::TAP_UPD_IR : jtd_pkg::TAP_PAU_IR;
      jtd_pkg::TAP_PAU_IR: state_next = tms ? jtd_pkg::TAP_EX2_IR : jtd_pkg::TAP_PAU_IR;
      jtd_pkg::TAP_EX2_IR: state_next = tms ? jtd_pkg::TAP_UPD_IR : jtd_pkg::TAP_SH_IR;
      jtd_pkg::TAP_UPD_IR: state_next = tms ? jtd_pkg::TAP_SEL_DR : jtd_pkg::TAP_IDLE;
      default:             state_next = jtd_pkg::TAP_TLR;
    endcase
  end

  always_comb begin
    ctrl.at_sh_dr  = (state == jtd_pkg::TAP_SH_DR);
    ctrl.at_sh_ir  = (state == jtd_pkg::TAP_SH_IR);
    ctrl.to_tlr    = (state_next == jtd_pkg::TAP_TLR);
    ctrl.to_cap_dr = (state_next == jtd_pkg::TAP_CAP_DR);
    ctrl.to_sh_dr  = (state_next == jtd_pkg::TAP_SH_DR);
    ctrl.to_sh_ir  = (state_next == jtd_pkg::TAP_SH_IR);
    ctrl.to_upd_dr = (state_next == jtd_pkg::TAP_UPD_DR);
  end

endmodule

// ----- src/jtd_regs.sv -----
// Instruction and data shift registers, capture and DMI update decode.
module jtd_regs #(
  parameter int unsigned ADDRESS_BITS = jtd_pkg::ADDRESS_BITS_DEF,
  parameter int unsigned IR_BITS      = jtd_pkg::IR_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  jtd_pkg::tap_ctrl_t          ctrl,
  input  logic                        tdi,
  input  logic                        rd_load,
  input  logic [jtd_pkg::DATA_W-1:0]  read_data,
  input  logic [jtd_pkg::DATA_W-1:0]  idcode_value,
  input  logic [jtd_pkg::HINT_W-1:0]  idle_hint,
  output logic                        tdo_next,
  output jtd_pkg::dm_req_t            req
);

  localparam int unsigned DR_W    = ADDRESS_BITS + jtd_pkg::DATA_W + jtd_pkg::DMI_OP_W;
  localparam int unsigned TOP_W   = $clog2(DR_W);
  localparam int unsigned ADDR_LO = jtd_pkg::DATA_W + jtd_pkg::DMI_OP_W;

  localparam logic [IR_BITS-1:0] CODE_IDCODE = IR_BITS'(jtd_pkg::IR_IDCODE);
  localparam logic [IR_BITS-1:0] CODE_DTMCS  = IR_BITS'(jtd_pkg::IR_DTMCS);
  localparam logic [IR_BITS-1:0] CODE_DMI    = IR_BITS'(jtd_pkg::IR_DMI);
  localparam logic [IR_BITS-1:0] CODE_BYPASS = IR_BITS'(jtd_pkg::IR_BYPASS);

  localparam logic [TOP_W-1:0] TOP_BYPASS = TOP_W'(0);
  localparam logic [TOP_W-1:0] TOP_WORD   = TOP_W'(jtd_pkg::DATA_W - 1);
  localparam logic [TOP_W-1:0] TOP_DMI    = TOP_W'(DR_W - 1);

  logic [IR_BITS-1:0]         ir;
  logic [IR_BITS-1:0]         ir_next;
  logic [DR_W-1:0]            dr;
  logic [DR_W-1:0]            dr_next;
  logic [TOP_W-1:0]           dr_top;      // data register length minus one
  logic [TOP_W-1:0]           dr_top_next;
  logic                       tdo_level;
  logic [jtd_pkg::DATA_W-1:0] last_read;
  logic [IR_BITS-1:0]         ir_shifted;
  logic [DR_W-1:0]            dr_shifted;
  logic [DR_W-1:0]            dtmcs_word;
  logic [jtd_pkg::DMI_OP_W-1:0] dmi_op;

  assign ir_shifted = {tdi, ir[IR_BITS-1:1]};
  assign dr_shifted = (dr >> 1) | (DR_W'(tdi) << dr_top);
  assign dtmcs_word = DR_W'({17'd0, idle_hint, 8'(ADDRESS_BITS), jtd_pkg::DTMCS_VERSION});
  assign dmi_op     = dr[jtd_pkg::DMI_OP_W-1:0];

  always_comb begin
    ir_next     = ir;
    dr_next     = dr;
    dr_top_next = dr_top;
    tdo_next    = tdo_level;
    if (step) begin
      if (ctrl.at_sh_dr) begin
        dr_next = dr_shifted;
      end
      if (ctrl.at_sh_ir) begin
        ir_next = ir_shifted;
      end
      if (ctrl.to_tlr) begin
        ir_next = CODE_IDCODE;
      end
      if (ctrl.to_cap_dr) begin
        unique case (ir)
          CODE_BYPASS: begin
            dr_next     = '0;
            dr_top_next = TOP_BYPASS;
          end
          CODE_IDCODE: begin
            dr_next     = DR_W'(idcode_value);
            dr_top_next = TOP_WORD;
          end
          CODE_DTMCS: begin
            dr_next     = dtmcs_word;
            dr_top_next = TOP_WORD;
          end
          CODE_DMI: begin
            dr_next     = DR_W'({last_read, 2'b00});
            dr_top_next = TOP_DMI;
          end
          default: begin
            // unknown instruction: keep the data register as it is
            dr_next     = dr;
            dr_top_next = dr_top;
          end
        endcase
      end
      if (ctrl.to_sh_dr) begin
        tdo_next = dr_next[0];
      end
      if (ctrl.to_sh_ir) begin
        tdo_next = ir_next[0];
      end
    end
  end

  always_comb begin
    req = '0;
    if (step && ctrl.to_upd_dr && (ir == CODE_DMI)) begin
      if (dmi_op == jtd_pkg::DMI_OP_READ) begin
        req.valid   = 1'b1;
        req.address = jtd_pkg::ADDR_OUT_W'(dr[ADDR_LO +: ADDRESS_BITS]);
      end else if (dmi_op == jtd_pkg::DMI_OP_WRITE) begin
        req.valid      = 1'b1;
        req.is_write   = 1'b1;
        req.address    = jtd_pkg::ADDR_OUT_W'(dr[ADDR_LO +: ADDRESS_BITS]);
        req.write_data = dr[jtd_pkg::DMI_OP_W +: jtd_pkg::DATA_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ir        <= CODE_IDCODE;
      dr        <= '0;
      dr_top    <= TOP_BYPASS;
      tdo_level <= 1'b0;
      last_read <= '0;
    end else begin
      ir        <= ir_next;
      dr        <= dr_next;
      dr_top    <= dr_top_next;
      tdo_level <= tdo_next;
      if (rd_load) begin
        last_read <= read_data;
      end
    end
  end

`ifndef SYNTHESIS
  // a request only ever leaves on entry to Update-DR
  assert property (@(posedge clk) disable iff (rst)
    req.valid |-> (step && ctrl.to_upd_dr && (ir == CODE_DMI)))
    else $error("jtd_regs: request outside Update-DR");

  // Test-Logic-Reset always leaves IDCODE selected
  assert property (@(posedge clk) disable iff (rst)
    (step && ctrl.to_tlr) |=> (ir == CODE_IDCODE))
    else $error("jtd_regs: IDCODE not selected after Test-Logic-Reset");
`endif

endmodule

// ----- src/jtag_tap_debug_transport_core.sv -----
// Top level: stream ports, input and result registers, configuration registers.
//
// JTAG TAP with a RISC-V debug transport. Each input item is one step: a pin
// sample (tuser 0), a read data return from the debug module (tuser 1) or a
// debug module reset request (tuser 2). Every item produces exactly one result
// carrying the held tdo level, any debug module access request and the reset
// pulse. Items are taken one per clock while the master side is not stalled;
// an item passes through an input register, one combinational TAP step and a
// result register, which presents its result on the master side. Throughput
// is one item per cycle while the master side accepts results; the TAP step
// updates the TAP state and shift registers, and a stalled master side holds
// both registers. Configuration (index 0 IDCODE value, index 1 idle hint) is
// to be written by the user through the cfg port only while no item is in
// flight; the block itself does not enforce this.
module jtag_tap_debug_transport_core #(
  parameter int unsigned ADDRESS_BITS = jtd_pkg::ADDRESS_BITS_DEF,
  parameter int unsigned IR_BITS      = jtd_pkg::IR_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // tck[0], tms[1], tdi[2], read_data[34:3], zero fill above
  input  logic [jtd_pkg::S_TDATA_W-1:0]        s_tdata,
  // mode[1:0]
  input  logic [jtd_pkg::MODE_W-1:0]           s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // tdo[0], req_valid[1], req_is_write[2], req_address[10:3],
  // req_write_data[42:11], reset_pulse[43], zero fill above
  output logic [jtd_pkg::M_TDATA_W-1:0]        m_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [jtd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [jtd_pkg::DATA_W-1:0]           cfg_data
);

  // input register
  logic                        in_valid;
  logic [jtd_pkg::MODE_W-1:0]  in_mode;
  logic                        in_tck;
  logic                        in_tms;
  logic                        in_tdi;
  logic [jtd_pkg::DATA_W-1:0]  in_read_data;

  // result register
  logic                        out_tdo;
  jtd_pkg::dm_req_t            out_req;
  logic                        out_reset_pulse;

  logic [jtd_pkg::DATA_W-1:0]  idcode_value;
  logic [jtd_pkg::HINT_W-1:0]  idle_hint;
  logic                        prev_tck;

  logic                        advance;
  logic                        fire;
  logic                        is_pin;
  logic                        tap_step;
  logic                        rd_load;
  logic                        tdo_next;
  jtd_pkg::dm_req_t            req;
  jtd_pkg::tap_ctrl_t          ctrl;

  assign advance  = !m_tvalid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;
  assign is_pin   = (in_mode == jtd_pkg::MODE_PIN);
  assign tap_step = fire && is_pin && !prev_tck && in_tck;
  assign rd_load  = fire && (in_mode == jtd_pkg::MODE_READ);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode      <= s_tuser;
      in_tck       <= s_tdata[0];
      in_tms       <= s_tdata[1];
      in_tdi       <= s_tdata[2];
      in_read_data <= s_tdata[3 +: jtd_pkg::DATA_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_tck <= 1'b0;
    end else if (fire && is_pin) begin
      prev_tck <= in_tck;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idcode_value <= jtd_pkg::IDCODE_RESET;
      idle_hint    <= jtd_pkg::IDLE_HINT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        jtd_pkg::CFG_IDCODE:    idcode_value <= cfg_data;
        jtd_pkg::CFG_IDLE_HINT: idle_hint    <= cfg_data[jtd_pkg::HINT_W-1:0];
        default:                ;
      endcase
    end
  end

  jtd_tap u_tap (
    .clk  (clk),
    .rst  (rst),
    .step (tap_step),
    .tms  (in_tms),
    .ctrl (ctrl)
  );

  jtd_regs #(
    .ADDRESS_BITS (ADDRESS_BITS),
    .IR_BITS      (IR_BITS)
  ) u_regs (
    .clk          (clk),
    .rst          (rst),
    .step         (tap_step),
    .ctrl         (ctrl),
    .tdi          (in_tdi),
    .rd_load      (rd_load),
    .read_data    (in_read_data),
    .idcode_value (idcode_value),
    .idle_hint    (idle_hint),
    .tdo_next     (tdo_next),
    .req          (req)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_tdo         <= tdo_next;
      out_req         <= req;
      out_reset_pulse <= (in_mode == jtd_pkg::MODE_RESET);
    end
  end

  assign m_tdata = {4'd0, out_reset_pulse, out_req.write_data, out_req.address,
                    out_req.is_write, out_req.valid, out_tdo};

`ifndef SYNTHESIS
  // every item taken from the input register yields a result
  assert property (@(posedge clk) disable iff (rst)
    fire |=> m_tvalid)
    else $error("core: result lost");

  // a stalled input register keeps its item
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> in_valid)
    else $error("core: stalled item dropped");

  // a write request is always a valid request
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_req.is_write) |-> out_req.valid)
    else $error("core: write flag without request");

  // a reset request never carries a debug module access
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_reset_pulse) |-> !out_req.valid)
    else $error("core: access and reset in one result");
`endif

endmodule
